>>> hdl/bpl_pkg.sv
// Shared types and codes for the buffer pool pin/LRU directory.
// No dependencies; used by bpl_slot_alu and buffer_pool_pin_lru_table_core.
`default_nettype none

package bpl_pkg;

    localparam int FILE_W   = 16;
    localparam int BLOCK_W  = 32;
    localparam int HANDLE_W = 32;
    localparam int CAP_W    = 5;
    localparam int FREE_W   = 6;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS     = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNPINNED = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Lookup key of one entry.
    typedef struct packed {
        logic [FILE_W-1:0]  file;
        logic [BLOCK_W-1:0] block;
    } key_t;

    // Per-slot edit selected by the sequencer during the update pass.
    typedef struct packed {
        logic leave;        // drop ranks above rank_arg by one
        logic evict_here;   // invalidate this slot
        logic fill_here;    // write the new pinned entry here
        logic repin_here;   // mark pinned, rank back to zero
        logic unpin_here;   // mark unpinned at tail rank
        logic handle_here;  // replace stored handle
    } slot_op_t;

endpackage

`default_nettype wire

>>> hdl/bpl_slot_ram.sv
// Slot memory: one write port, one registered read port.
// No dependencies.
`default_nettype none

module bpl_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 86
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/bpl_slot_alu.sv
// Shared per-slot unit: key compare / victim test on the scan pass,
// record rewrite on the update pass. Depends on bpl_pkg.
`default_nettype none

module bpl_slot_alu import bpl_pkg::*; #(
    parameter int RW = 4
) (
    input  wire key_t                   req_key,
    input  wire logic [HANDLE_W-1:0]    req_handle,
    input  wire logic                   rec_valid,
    input  wire logic                   rec_pinned,
    input  wire logic [RW-1:0]          rec_rank,
    input  wire key_t                   rec_key,
    input  wire logic [HANDLE_W-1:0]    rec_handle,
    input  wire slot_op_t               op,
    input  wire logic [RW-1:0]          rank_arg,
    output logic                        hit,
    output logic                        free,
    output logic                        cand,
    output logic                        nxt_valid,
    output logic                        nxt_pinned,
    output logic [RW-1:0]               nxt_rank,
    output key_t                        nxt_key,
    output logic [HANDLE_W-1:0]         nxt_handle
);

    assign hit  = rec_valid && (rec_key == req_key);
    assign free = !rec_valid;
    assign cand = rec_valid && !rec_pinned && (rec_rank == '0);

    always_comb
    begin
        nxt_valid  = rec_valid;
        nxt_pinned = rec_pinned;
        nxt_rank   = rec_rank;
        nxt_key    = rec_key;
        nxt_handle = rec_handle;

        if (op.leave && rec_valid && !rec_pinned && (rec_rank > rank_arg))
        begin
            nxt_rank = rec_rank - RW'(1);
        end
        if (op.evict_here)
        begin
            nxt_valid = 1'b0;
        end
        if (op.repin_here)
        begin
            nxt_pinned = 1'b1;
            nxt_rank   = '0;
        end
        if (op.unpin_here)
        begin
            nxt_pinned = 1'b0;
            nxt_rank   = rank_arg;
        end
        if (op.handle_here)
        begin
            nxt_handle = req_handle;
        end
        // a fill may land on the slot just evicted; it wins
        if (op.fill_here)
        begin
            nxt_valid  = 1'b1;
            nxt_pinned = 1'b1;
            nxt_rank   = '0;
            nxt_key    = req_key;
            nxt_handle = req_handle;
        end
    end

endmodule

`default_nettype wire

>>> hdl/buffer_pool_pin_lru_table_core.sv
// Buffer pool directory with pinning and least-recently-unpinned eviction.
// Depends on bpl_pkg, bpl_slot_ram, bpl_slot_alu.
//
//   Channel  Handshake             Payload
//   -------  --------------------  ----------------------------------------------
//   in       in_valid / in_ready   command, file_id, block_number, frame_handle
//   out      out_valid / out_ready status, found_handle, evicted, evicted_file,
//                                  evicted_block, free_space
//   cfg      cfg_valid / cfg_ready cfg_data (capacity)
//
// A request makes one scan pass over the slot memory and, when it edits the
// table, one read-modify-write pass as well, one slot per cycle through its
// single read port. After reset the memory is cleared, one slot per cycle;
// in_ready stays low meanwhile, cfg writes are taken. A finished result sits
// in the output register, so the next request is taken while out_ready is low.
`default_nettype none

module buffer_pool_pin_lru_table_core import bpl_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [CMD_W-1:0]           command,
    input  wire logic [FILE_W-1:0]          file_id,
    input  wire logic [BLOCK_W-1:0]         block_number,
    input  wire logic [HANDLE_W-1:0]        frame_handle,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [STAT_W-1:0]               status,
    output logic [HANDLE_W-1:0]             found_handle,
    output logic                            evicted,
    output logic [FILE_W-1:0]               evicted_file,
    output logic [BLOCK_W-1:0]              evicted_block,
    output logic signed [FREE_W-1:0]        free_space,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CAP_W-1:0]           cfg_data
);

    // index / rank width and count width
    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam int FSW  = CMPW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
    localparam logic signed [FSW-1:0] FS_HI = FSW'(31);
    localparam logic signed [FSW-1:0] FS_LO = FSW'(-32);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SCAN_END = 3'd3;
    localparam logic [2:0] S_DECIDE   = 3'd4;
    localparam logic [2:0] S_UPDATE   = 3'd5;
    localparam logic [2:0] S_UPD_END  = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    typedef struct packed {
        logic                valid;
        logic                pinned;
        logic [IW-1:0]       rank;
        key_t                key;
        logic [HANDLE_W-1:0] handle;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    // sequencer
    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          pipe_vld_reg, pipe_vld_next;
    logic          pipe_upd_reg, pipe_upd_next;
    logic [IW-1:0] pipe_idx_reg, pipe_idx_next;

    // captured request
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    key_t                key_reg, key_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;

    // scan findings
    logic                hit_found_reg, hit_found_next;
    logic [IW-1:0]       hit_idx_reg, hit_idx_next;
    logic                hit_pinned_reg, hit_pinned_next;
    logic [IW-1:0]       hit_rank_reg, hit_rank_next;
    logic [HANDLE_W-1:0] hit_handle_reg, hit_handle_next;
    logic                free_found_reg, free_found_next;
    logic [IW-1:0]       free_idx_reg, free_idx_next;
    logic                vic_found_reg, vic_found_next;
    logic [IW-1:0]       vic_idx_reg, vic_idx_next;
    key_t                vic_key_reg, vic_key_next;

    // edit plan for the update pass
    logic          leave_reg, leave_next;
    logic          evict_reg, evict_next;
    logic          fill_reg, fill_next;
    logic [IW-1:0] fill_idx_reg, fill_idx_next;
    logic          repin_reg, repin_next;
    logic          unpin_reg, unpin_next;
    logic          sethdl_reg, sethdl_next;
    logic [IW-1:0] rank_arg_reg, rank_arg_next;

    // pending result
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_found_reg, res_found_next;
    logic                res_ev_reg, res_ev_next;
    key_t                res_evkey_reg, res_evkey_next;

    // counters and config
    logic [CW-1:0]    pinned_count_reg, pinned_count_next;
    logic [CW-1:0]    unpinned_count_reg, unpinned_count_next;
    logic [CAP_W-1:0] capacity_reg, capacity_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]       status_reg, status_next;
    logic [HANDLE_W-1:0]     found_handle_reg, found_handle_next;
    logic                    evicted_reg, evicted_next;
    key_t                    evkey_reg, evkey_next;
    logic signed [FREE_W-1:0] free_space_reg, free_space_next;

    // memory and shared unit hookup
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic [REC_W-1:0] rd_data;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [REC_W-1:0] wr_data;
    slot_rec_t        rd_rec;
    slot_rec_t        upd_rec;
    slot_op_t         slot_op;
    logic             alu_hit, alu_free, alu_cand;

    logic                  need_evict;
    logic signed [FSW-1:0] fs_diff;
    logic                  in_acc;
    logic                  out_load;

    assign rd_rec = slot_rec_t'(rd_data);

    bpl_slot_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (REC_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bpl_slot_alu #(
        .RW (IW)
    ) u_alu (
        .req_key    (key_reg),
        .req_handle (handle_reg),
        .rec_valid  (rd_rec.valid),
        .rec_pinned (rd_rec.pinned),
        .rec_rank   (rd_rec.rank),
        .rec_key    (rd_rec.key),
        .rec_handle (rd_rec.handle),
        .op         (slot_op),
        .rank_arg   (rank_arg_reg),
        .hit        (alu_hit),
        .free       (alu_free),
        .cand       (alu_cand),
        .nxt_valid  (upd_rec.valid),
        .nxt_pinned (upd_rec.pinned),
        .nxt_rank   (upd_rec.rank),
        .nxt_key    (upd_rec.key),
        .nxt_handle (upd_rec.handle)
    );

    // per-slot edit; only meaningful while the update pass writes back
    always_comb
    begin
        slot_op.leave       = leave_reg;
        slot_op.evict_here  = evict_reg  && (pipe_idx_reg == vic_idx_reg);
        slot_op.fill_here   = fill_reg   && (pipe_idx_reg == fill_idx_reg);
        slot_op.repin_here  = repin_reg  && (pipe_idx_reg == hit_idx_reg);
        slot_op.unpin_here  = unpin_reg  && (pipe_idx_reg == hit_idx_reg);
        slot_op.handle_here = sethdl_reg && (pipe_idx_reg == hit_idx_reg);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign need_evict = (CMPW'(pinned_count_reg) >= CMPW'(capacity_reg)) || !free_found_reg;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign fs_diff   = $signed({1'b0, CMPW'(capacity_reg)})
                     - $signed({1'b0, CMPW'(pinned_count_reg)});

    always_comb
    begin
        state_next          = state_reg;
        idx_next            = idx_reg;
        pipe_vld_next       = 1'b0;
        pipe_upd_next       = pipe_upd_reg;
        pipe_idx_next       = pipe_idx_reg;
        cmd_next            = cmd_reg;
        key_next            = key_reg;
        handle_next         = handle_reg;
        hit_found_next      = hit_found_reg;
        hit_idx_next        = hit_idx_reg;
        hit_pinned_next     = hit_pinned_reg;
        hit_rank_next       = hit_rank_reg;
        hit_handle_next     = hit_handle_reg;
        free_found_next     = free_found_reg;
        free_idx_next       = free_idx_reg;
        vic_found_next      = vic_found_reg;
        vic_idx_next        = vic_idx_reg;
        vic_key_next        = vic_key_reg;
        leave_next          = leave_reg;
        evict_next          = evict_reg;
        fill_next           = fill_reg;
        fill_idx_next       = fill_idx_reg;
        repin_next          = repin_reg;
        unpin_next          = unpin_reg;
        sethdl_next         = sethdl_reg;
        rank_arg_next       = rank_arg_reg;
        res_status_next     = res_status_reg;
        res_found_next      = res_found_reg;
        res_ev_next         = res_ev_reg;
        res_evkey_next      = res_evkey_reg;
        pinned_count_next   = pinned_count_reg;
        unpinned_count_next = unpinned_count_reg;
        capacity_next       = capacity_reg;
        rd_en               = 1'b0;
        rd_addr             = idx_reg;
        wr_en               = 1'b0;
        wr_addr             = pipe_idx_reg;
        wr_data             = upd_rec;

        if (cfg_valid && cfg_ready)
        begin
            capacity_next = cfg_data;
        end

        // record coming out of the memory: scan bookkeeping or write-back
        if (pipe_vld_reg && !pipe_upd_reg)
        begin
            if (alu_hit && !hit_found_reg)
            begin
                hit_found_next  = 1'b1;
                hit_idx_next    = pipe_idx_reg;
                hit_pinned_next = rd_rec.pinned;
                hit_rank_next   = rd_rec.rank;
                hit_handle_next = rd_rec.handle;
            end
            if (alu_free && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = pipe_idx_reg;
            end
            if (alu_cand && !vic_found_reg)
            begin
                vic_found_next = 1'b1;
                vic_idx_next   = pipe_idx_reg;
                vic_key_next   = rd_rec.key;
            end
        end
        if (pipe_vld_reg && pipe_upd_reg)
        begin
            wr_en = 1'b1;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = '0;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next        = command;
                    key_next.file   = file_id;
                    key_next.block  = block_number;
                    handle_next     = frame_handle;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    vic_found_next  = 1'b0;
                    idx_next        = '0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN, S_UPDATE:
            begin
                rd_en         = 1'b1;
                pipe_vld_next = 1'b1;
                pipe_upd_next = (state_reg == S_UPDATE);
                pipe_idx_next = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = (state_reg == S_UPDATE) ? S_UPD_END : S_SCAN_END;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                leave_next      = 1'b0;
                evict_next      = 1'b0;
                fill_next       = 1'b0;
                fill_idx_next   = free_idx_reg;
                repin_next      = 1'b0;
                unpin_next      = 1'b0;
                sethdl_next     = 1'b0;
                rank_arg_next   = '0;
                res_status_next = ST_OK;
                res_found_next  = '0;
                res_ev_next     = 1'b0;
                res_evkey_next  = '0;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (hit_found_reg)
                        begin
                            sethdl_next = 1'b1;
                            repin_next  = 1'b1;
                            if (!hit_pinned_reg)
                            begin
                                leave_next          = 1'b1;
                                rank_arg_next       = hit_rank_reg;
                                pinned_count_next   = pinned_count_reg + CW'(1);
                                unpinned_count_next = unpinned_count_reg - CW'(1);
                            end
                        end
                        else if (need_evict)
                        begin
                            if (!vic_found_reg)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                // oldest unpinned entry goes, its rank is zero
                                res_ev_next         = 1'b1;
                                res_evkey_next      = vic_key_reg;
                                evict_next          = 1'b1;
                                leave_next          = 1'b1;
                                fill_next           = 1'b1;
                                fill_idx_next       = free_found_reg ? free_idx_reg
                                                                     : vic_idx_reg;
                                pinned_count_next   = pinned_count_reg + CW'(1);
                                unpinned_count_next = unpinned_count_reg - CW'(1);
                            end
                        end
                        else
                        begin
                            fill_next         = 1'b1;
                            pinned_count_next = pinned_count_reg + CW'(1);
                        end
                    end
                    CMD_UNPIN:
                    begin
                        if (!hit_found_reg)
                        begin
                            res_status_next = ST_MISS;
                        end
                        else if (!hit_pinned_reg)
                        begin
                            res_status_next = ST_UNPINNED;
                        end
                        else
                        begin
                            // new tail of the unpinned order
                            unpin_next          = 1'b1;
                            rank_arg_next       = unpinned_count_reg[IW-1:0];
                            unpinned_count_next = unpinned_count_reg + CW'(1);
                            if (pinned_count_reg != '0)
                            begin
                                pinned_count_next = pinned_count_reg - CW'(1);
                            end
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (!hit_found_reg)
                        begin
                            res_status_next = ST_MISS;
                        end
                        else
                        begin
                            res_found_next = hit_handle_reg;
                            repin_next     = 1'b1;
                            if (!hit_pinned_reg)
                            begin
                                leave_next          = 1'b1;
                                rank_arg_next       = hit_rank_reg;
                                pinned_count_next   = pinned_count_reg + CW'(1);
                                unpinned_count_next = unpinned_count_reg - CW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
                if ((cmd_reg == CMD_INSERT && (hit_found_reg || !need_evict || vic_found_reg))
                    || (cmd_reg == CMD_UNPIN && hit_found_reg && hit_pinned_reg)
                    || (cmd_reg == CMD_LOOKUP && hit_found_reg))
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_UPD_END:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        found_handle_next = found_handle_reg;
        evicted_next      = evicted_reg;
        evkey_next        = evkey_reg;
        free_space_next   = free_space_reg;
        if (out_load)
        begin
            out_valid_next    = 1'b1;
            status_next       = res_status_reg;
            found_handle_next = res_found_reg;
            evicted_next      = res_ev_reg;
            evkey_next        = res_evkey_reg;
            if (fs_diff > FS_HI)
            begin
                free_space_next = FS_HI[FREE_W-1:0];
            end
            else if (fs_diff < FS_LO)
            begin
                free_space_next = FS_LO[FREE_W-1:0];
            end
            else
            begin
                free_space_next = fs_diff[FREE_W-1:0];
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found_handle  = found_handle_reg;
    assign evicted       = evicted_reg;
    assign evicted_file  = evkey_reg.file;
    assign evicted_block = evkey_reg.block;
    assign free_space    = free_space_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            idx_reg            <= '0;
            pipe_vld_reg       <= 1'b0;
            pipe_upd_reg       <= 1'b0;
            hit_found_reg      <= 1'b0;
            free_found_reg     <= 1'b0;
            vic_found_reg      <= 1'b0;
            leave_reg          <= 1'b0;
            evict_reg          <= 1'b0;
            fill_reg           <= 1'b0;
            repin_reg          <= 1'b0;
            unpin_reg          <= 1'b0;
            sethdl_reg         <= 1'b0;
            pinned_count_reg   <= '0;
            unpinned_count_reg <= '0;
            capacity_reg       <= CAP_RESET;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            idx_reg            <= idx_next;
            pipe_vld_reg       <= pipe_vld_next;
            pipe_upd_reg       <= pipe_upd_next;
            hit_found_reg      <= hit_found_next;
            free_found_reg     <= free_found_next;
            vic_found_reg      <= vic_found_next;
            leave_reg          <= leave_next;
            evict_reg          <= evict_next;
            fill_reg           <= fill_next;
            repin_reg          <= repin_next;
            unpin_reg          <= unpin_next;
            sethdl_reg         <= sethdl_next;
            pinned_count_reg   <= pinned_count_next;
            unpinned_count_reg <= unpinned_count_next;
            capacity_reg       <= capacity_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        pipe_idx_reg     <= pipe_idx_next;
        cmd_reg          <= cmd_next;
        key_reg          <= key_next;
        handle_reg       <= handle_next;
        hit_idx_reg      <= hit_idx_next;
        hit_pinned_reg   <= hit_pinned_next;
        hit_rank_reg     <= hit_rank_next;
        hit_handle_reg   <= hit_handle_next;
        free_idx_reg     <= free_idx_next;
        vic_idx_reg      <= vic_idx_next;
        vic_key_reg      <= vic_key_next;
        fill_idx_reg     <= fill_idx_next;
        rank_arg_reg     <= rank_arg_next;
        res_status_reg   <= res_status_next;
        res_found_reg    <= res_found_next;
        res_ev_reg       <= res_ev_next;
        res_evkey_reg    <= res_evkey_next;
        status_reg       <= status_next;
        found_handle_reg <= found_handle_next;
        evicted_reg      <= evicted_next;
        evkey_reg        <= evkey_next;
        free_space_reg   <= free_space_next;
    end

`ifndef SYNTHESIS
    // write-back trails the read by one slot, never the same address
    a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("slot memory read and write hit the same address");

    // every counted entry occupies a slot
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (({1'b0, pinned_count_reg} + {1'b0, unpinned_count_reg})
            <= (CW + 1)'(TABLE_DEPTH)))
        else $error("pinned plus unpinned count exceeds table depth");

    // counters move only when the edit plan is made
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DECIDE) |=>
            ($stable(pinned_count_reg) && $stable(unpinned_count_reg)))
        else $error("entry counters changed outside the decision step");

    // an eviction is only reported on a successful request
    a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && evicted_reg) |-> (status_reg == ST_OK))
        else $error("eviction reported with a failing status");
`endif

endmodule

`default_nettype wire

>>> tb/bpl_tb_pkg.sv
// Request and reply records plus the directory scoreboard for the pin/LRU table bench.
// Depends on bpl_pkg for field widths and command and status codes.
package bpl_tb_pkg;

    import bpl_pkg::*;

    localparam int SLOTS = 16;

    // Reserved command value, treated as a no-op by the block.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [FILE_W-1:0]   file_id;
        logic [BLOCK_W-1:0]  block_number;
        logic [HANDLE_W-1:0] frame_handle;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [HANDLE_W-1:0] found_handle;
        logic                evicted;
        logic [FILE_W-1:0]   evicted_file;
        logic [BLOCK_W-1:0]  evicted_block;
        logic [FREE_W-1:0]   free_space;
    } reply_t;

    class directory_scoreboard;

        bit                  slot_used [SLOTS];
        logic [FILE_W-1:0]   slot_file [SLOTS];
        logic [BLOCK_W-1:0]  slot_block [SLOTS];
        logic [HANDLE_W-1:0] slot_handle [SLOTS];
        bit                  slot_pin [SLOTS];
        int                  slot_age [SLOTS];   // 0 = oldest unpinned
        int                  n_pinned;
        int                  n_unpinned;
        int                  cap;
        reply_t              replies_due [$];
        int                  mismatches;
        int                  n_requests;
        int                  n_hits;
        int                  n_evictions;
        int                  n_rejects;

        function new();
            foreach (slot_used[i])
            begin
                slot_used[i] = 1'b0;
                slot_pin[i]  = 1'b0;
                slot_age[i]  = 0;
            end
            n_pinned    = 0;
            n_unpinned  = 0;
            cap         = int'(CAP_RESET);
            mismatches  = 0;
            n_requests  = 0;
            n_hits      = 0;
            n_evictions = 0;
            n_rejects   = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            cap = int'(value);
        endfunction

        function int replies_waiting();
            return replies_due.size();
        endfunction

        function int slot_of(logic [FILE_W-1:0] f, logic [BLOCK_W-1:0] b);
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && slot_file[i] == f && slot_block[i] == b)
                    return i;
            return -1;
        endfunction

        // Pull an unpinned slot out of the eviction order, closing the gap.
        function void drop_from_order(int s);
            int r;
            r = slot_age[s];
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && !slot_pin[i] && slot_age[i] > r)
                    slot_age[i]--;
            slot_age[s] = 0;
            if (n_unpinned > 0)
                n_unpinned--;
        endfunction

        function void pin_slot(int s);
            if (!slot_pin[s])
            begin
                drop_from_order(s);
                slot_pin[s] = 1'b1;
                n_pinned++;
            end
        endfunction

        function reply_t apply_to_directory(request_t r);
            reply_t y;
            int     s;
            int     free_slot;
            int     victim;
            int     room;
            y = '0;
            s = slot_of(r.file_id, r.block_number);
            case (r.command)
                CMD_INSERT:
                begin
                    if (s >= 0)
                    begin
                        slot_handle[s] = r.frame_handle;
                        pin_slot(s);
                    end
                    else
                    begin
                        free_slot = -1;
                        victim    = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (!slot_used[i])
                            begin
                                free_slot = i;
                                break;
                            end
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_used[i] && !slot_pin[i] && slot_age[i] == 0)
                            begin
                                victim = i;
                                break;
                            end
                        if (n_pinned >= cap || free_slot < 0)
                        begin
                            if (victim < 0)
                            begin
                                y.status = ST_FULL;
                                n_rejects++;
                            end
                            else
                            begin
                                y.evicted       = 1'b1;
                                y.evicted_file  = slot_file[victim];
                                y.evicted_block = slot_block[victim];
                                drop_from_order(victim);
                                slot_used[victim] = 1'b0;
                                if (free_slot < 0)
                                    free_slot = victim;
                                n_evictions++;
                            end
                        end
                        if (y.status == ST_OK && free_slot >= 0)
                        begin
                            slot_used[free_slot]   = 1'b1;
                            slot_file[free_slot]   = r.file_id;
                            slot_block[free_slot]  = r.block_number;
                            slot_handle[free_slot] = r.frame_handle;
                            slot_pin[free_slot]    = 1'b1;
                            slot_age[free_slot]    = 0;
                            n_pinned++;
                        end
                    end
                end
                CMD_UNPIN:
                begin
                    if (s < 0)
                        y.status = ST_MISS;
                    else if (!slot_pin[s])
                        y.status = ST_UNPINNED;
                    else
                    begin
                        slot_pin[s] = 1'b0;
                        slot_age[s] = n_unpinned;
                        n_unpinned++;
                        if (n_pinned > 0)
                            n_pinned--;
                    end
                end
                CMD_LOOKUP:
                begin
                    if (s < 0)
                        y.status = ST_MISS;
                    else
                    begin
                        y.found_handle = slot_handle[s];
                        pin_slot(s);
                        n_hits++;
                    end
                end
                default:
                begin
                end
            endcase
            room = cap - n_pinned;
            if (room > 31)
                room = 31;
            if (room < -32)
                room = -32;
            y.free_space = room[FREE_W-1:0];
            return y;
        endfunction

        function void note_request(request_t r);
            replies_due.push_back(apply_to_directory(r));
            n_requests++;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                report_mismatch("reply with no request outstanding");
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.found_handle !== want.found_handle)
                report_mismatch($sformatf("found_handle %h, want %h",
                                          got.found_handle, want.found_handle));
            if (got.evicted !== want.evicted)
                report_mismatch($sformatf("evicted %b, want %b", got.evicted, want.evicted));
            if (got.evicted_file !== want.evicted_file)
                report_mismatch($sformatf("evicted_file %h, want %h",
                                          got.evicted_file, want.evicted_file));
            if (got.evicted_block !== want.evicted_block)
                report_mismatch($sformatf("evicted_block %h, want %h",
                                          got.evicted_block, want.evicted_block));
            if (got.free_space !== want.free_space)
                report_mismatch($sformatf("free_space %0d, want %0d",
                                          $signed(got.free_space), $signed(want.free_space)));
        endtask

    endclass

endpackage

>>> tb/tb.sv
// Top-level bench for buffer_pool_pin_lru_table_core: drives requests, capacity writes
// and reply backpressure, and checks every reply. Depends on bpl_pkg and bpl_tb_pkg.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bpl_pkg::*;
    import bpl_tb_pkg::*;

    localparam int KEY_POOL     = 22;     // more keys than slots, so the table overflows
    localparam int PHASE_ITEMS  = 83;
    localparam int SETTLE_CYCLES = 40;    // a bit over a request that edits the table
    localparam int LONG_STALL   = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     command;
    logic [FILE_W-1:0]    file_id;
    logic [BLOCK_W-1:0]   block_number;
    logic [HANDLE_W-1:0]  frame_handle;
    logic                 out_valid;
    logic                 out_ready;
    logic [STAT_W-1:0]    status;
    logic [HANDLE_W-1:0]  found_handle;
    logic                 evicted;
    logic [FILE_W-1:0]    evicted_file;
    logic [BLOCK_W-1:0]   evicted_block;
    logic signed [FREE_W-1:0] free_space;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data;

    directory_scoreboard sb = new();

    // Idle odds in percent, and the countdown of a forced reply stall.
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   reply_hold_cycles;

    logic [FILE_W-1:0]    pool_file [KEY_POOL];
    logic [BLOCK_W-1:0]   pool_block [KEY_POOL];
    logic [CAP_W-1:0]     phase_cap [6];
    reply_t               seen;

    buffer_pool_pin_lru_table_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .file_id       (file_id),
        .block_number  (block_number),
        .frame_handle  (frame_handle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .found_handle  (found_handle),
        .evicted       (evicted),
        .evicted_file  (evicted_file),
        .evicted_block (evicted_block),
        .free_space    (free_space),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs somewhere.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Reply side: ready is decided at the falling edge. A forced stall overrides the
    // random idling so the block backs up into its request port.
    always @(negedge clk)
    begin
        if (reply_hold_cycles > 0)
        begin
            out_ready = 1'b0;
            reply_hold_cycles--;
        end
        else
            out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Replies are taken at the rising edge where valid and ready meet.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.status        = status;
            seen.found_handle  = found_handle;
            seen.evicted       = evicted;
            seen.evicted_file  = evicted_file;
            seen.evicted_block = evicted_block;
            seen.free_space    = free_space;
            sb.check_reply(seen);
        end
    end

    // Offer one request; entered and left at a falling edge. Valid stays up across
    // back-to-back requests, only the payload changes.
    task automatic send_request(input request_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        command      = r.command;
        file_id      = r.file_id;
        block_number = r.block_number;
        frame_handle = r.frame_handle;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic [CMD_W-1:0] c, input logic [FILE_W-1:0] f,
                               input logic [BLOCK_W-1:0] b, input logic [HANDLE_W-1:0] h);
        request_t r;
        r.command      = c;
        r.file_id      = f;
        r.block_number = b;
        r.frame_handle = h;
        send_request(r);
    endtask

    // Stop offering and wait for every outstanding reply, then let the block go quiet.
    task automatic drain_replies();
        in_valid = 1'b0;
        while (sb.replies_waiting() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Capacity write; only called with the block idle.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_capacity(value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly keys from a small pool so hits, unpins and evictions are common;
    // the rest are fresh random keys that miss or crowd the table.
    function automatic request_t random_request();
        request_t r;
        int       pick;
        int       k;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.command = CMD_INSERT;
        else if (pick < 68)
            r.command = CMD_UNPIN;
        else if (pick < 95)
            r.command = CMD_LOOKUP;
        else
            r.command = CMD_SPARE;
        if ($urandom_range(0, 99) < 88)
        begin
            k = $urandom_range(0, KEY_POOL - 1);
            r.file_id      = pool_file[k];
            r.block_number = pool_block[k];
        end
        else
        begin
            r.file_id      = FILE_W'($urandom);
            r.block_number = $urandom;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
            r.frame_handle = '0;
        else if (pick == 1)
            r.frame_handle = '1;
        else
            r.frame_handle = $urandom;
        return r;
    endfunction

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        command           = CMD_INSERT;
        file_id           = '0;
        block_number      = '0;
        frame_handle      = '0;
        out_ready         = 1'b0;
        cfg_valid         = 1'b0;
        cfg_data          = CAP_RESET;
        send_idle_pct     = 23;
        recv_idle_pct     = 51;
        reply_hold_cycles = 0;

        // Key pool, with the all-zero and all-one keys always in it.
        for (int i = 0; i < KEY_POOL; i++)
        begin
            pool_file[i]  = FILE_W'($urandom);
            pool_block[i] = $urandom;
        end
        pool_file[0]  = '0;
        pool_block[0] = '0;
        pool_file[1]  = '1;
        pool_block[1] = '1;

        // Capacity per random phase: one, reset value, zero, the 5-bit top, others.
        phase_cap[0] = 5'd1;
        phase_cap[1] = 5'd16;
        phase_cap[2] = 5'd0;
        phase_cap[3] = 5'd31;
        phase_cap[4] = 5'd7;
        phase_cap[5] = 5'd3;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, at reset capacity: miss on an empty table, the spare command
        // with every bit set, and an insert with all-one key and handle.
        send_fields(CMD_LOOKUP, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_fields(CMD_SPARE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_replies();

        // Directed, capacity 2: reject when nothing is evictable, unpin miss and
        // double unpin, handle replace on a present key, eviction of the oldest
        // unpinned entry, re-pin past capacity (negative free space), lookup miss
        // after eviction, and insert of a present but unpinned key.
        write_capacity(5'd2);
        send_fields(CMD_INSERT, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_fields(CMD_INSERT, 16'h0001, 32'h0000_0001, 32'h1111_1111);
        send_fields(CMD_UNPIN,  16'h0001, 32'h0000_0001, 32'h0000_0000);
        send_fields(CMD_UNPIN,  16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_fields(CMD_UNPIN,  16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_fields(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_fields(CMD_INSERT, 16'h0001, 32'h0000_0001, 32'h1111_1111);
        send_fields(CMD_INSERT, 16'h0002, 32'h0000_0002, 32'h2222_2222);
        send_fields(CMD_UNPIN,  16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_fields(CMD_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_fields(CMD_LOOKUP, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        send_fields(CMD_UNPIN,  16'h0001, 32'h0000_0001, 32'h0000_0000);
        send_fields(CMD_UNPIN,  16'h0002, 32'h0000_0002, 32'h0000_0000);
        send_fields(CMD_INSERT, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_fields(CMD_INSERT, 16'h0003, 32'h8000_0000, 32'h3333_3333);
        send_fields(CMD_LOOKUP, 16'h0002, 32'h0000_0002, 32'h0000_0000);
        send_fields(CMD_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_fields(CMD_UNPIN,  16'h0003, 32'h8000_0000, 32'h0000_0000);
        send_fields(CMD_INSERT, 16'h0003, 32'h8000_0000, 32'h4444_4444);
        send_fields(CMD_SPARE,  16'h0000, 32'h0000_0000, 32'h0000_0000);

        // Random phases. Idling: sender light / receiver heavy, then swapped,
        // then none at all.
        for (int p = 0; p < 6; p++)
        begin
            drain_replies();
            write_capacity(phase_cap[p]);
            if (p < 2)
            begin
                send_idle_pct = 23;
                recv_idle_pct = 51;
            end
            else if (p < 4)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 23;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Long reply stall while requests keep coming: the block must
                // fill and drop in_ready.
                if (p == 1 && n == 20)
                    reply_hold_cycles = LONG_STALL;
                // Sender goes quiet until every reply is back, then resumes.
                if (p == 3 && n == 30)
                begin
                    in_valid = 1'b0;
                    while (sb.replies_waiting() != 0)
                        @(negedge clk);
                end
                send_request(random_request());
            end
        end
        drain_replies();

        $display("Run covered %0d requests: %0d lookup hits, %0d evictions, %0d rejected inserts.",
                 sb.n_requests, sb.n_hits, sb.n_evictions, sb.n_rejects);
        $display("Capacities 16, 2, 1, 16, 0, 31, 7, 3 under mixed idling and a long reply stall.");
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
